>>> hdl/utf8_to_utf16_decoder_defines.svh
// Assertion macros shared by the decoder RTL.
`ifndef UTF8_TO_UTF16_DECODER_DEFINES_SVH
`define UTF8_TO_UTF16_DECODER_DEFINES_SVH

`ifndef SYNTHESIS

// Check a property on every clock edge outside reset.
`define U8U16_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("u8u16 assertion failed");

// Check that a condition leads to an expression on the next edge.
`define U8U16_ASSERT_NEXT(lbl, cond, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error("u8u16 next-cycle assertion failed");

`else

`define U8U16_ASSERT(lbl, prop)
`define U8U16_ASSERT_NEXT(lbl, cond, expr)

`endif

`endif

>>> hdl/u8u16_pkg.sv
// Types and constants shared by the UTF-8 to UTF-16 decoder.
`default_nettype none

package u8u16_pkg;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_TRUNC   = 2'd1,
    ST_ILLEGAL = 2'd2
  } status_t;

  typedef struct packed {
    logic [15:0] unit;
    status_t     status;
    logic        last;
  } result_t;

  // Results produced by one accepted byte: zero, one or two.
  typedef struct packed {
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
  } dec_out_t;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam logic [20:0] CP_PLANE1   = 21'h010000;
  localparam logic [20:0] CP_BMP_MAX  = 21'h00FFFF;
  localparam logic [20:0] CP_MAX      = 21'h10FFFF;
  localparam logic [20:0] CP_SURR_LO  = 21'h00D800;
  localparam logic [20:0] CP_SURR_HI  = 21'h00DFFF;
  localparam logic [15:0] REPL_CHAR   = 16'hFFFD;
  localparam logic [5:0]  HI_SURR_TAG = 6'b110110;
  localparam logic [5:0]  LO_SURR_TAG = 6'b110111;

  localparam logic [7:0] LEAD_MIN_OK = 8'hC2;
  localparam logic [7:0] LEAD_MAX_OK = 8'hF4;
  localparam logic [7:0] LEAD_E0     = 8'hE0;
  localparam logic [7:0] LEAD_F0     = 8'hF0;
  localparam logic [7:0] LEAD_F4     = 8'hF4;
  localparam logic [7:0] CONT_MIN    = 8'h80;
  localparam logic [7:0] CONT_MAX    = 8'hBF;
  localparam logic [7:0] E0_SEC_MIN  = 8'hA0;
  localparam logic [7:0] F0_SEC_MIN  = 8'h90;
  localparam logic [7:0] F4_SEC_MAX  = 8'h8F;

endpackage

`default_nettype wire

>>> hdl/u8u16_seq.sv
// Sequence collector, legality check and UTF-16 conversion for one byte.
`default_nettype none
`include "utf8_to_utf16_decoder_defines.svh"

module u8u16_seq import u8u16_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic       cfg_strict,
  input  wire logic       in_fire,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_eos,
  output dec_out_t        res
);

  logic        strict_r;
  logic [7:0]  lead_r, lead_nxt;
  logic [2:0]  total_r, total_nxt;
  logic [2:0]  pending_r, pending_nxt;
  logic [7:0]  second_r, second_nxt;
  logic        tail_r, tail_nxt;
  logic [20:0] acc_r, acc_nxt;
  logic        disc_r, disc_nxt;

  logic [2:0]  trail;
  logic [7:0]  upd_lead;
  logic [2:0]  upd_total;
  logic [2:0]  upd_pending;
  logic [7:0]  upd_second;
  logic        upd_tail;
  logic [20:0] upd_acc;

  logic        len_bad;
  logic        lead_bad;
  logic        second_bad;
  logic        is_bmp;
  logic        is_surr;
  logic        is_over;
  logic        illegal;
  logic [20:0] ch_off;

  function automatic logic [2:0] trail_count(input logic [7:0] b);
    priority if (b < 8'hC0) trail_count = 3'd0;
    else if (b < 8'hE0)     trail_count = 3'd1;
    else if (b < 8'hF0)     trail_count = 3'd2;
    else if (b < 8'hF8)     trail_count = 3'd3;
    else if (b < 8'hFC)     trail_count = 3'd4;
    else                    trail_count = 3'd5;
  endfunction

  function automatic logic [7:0] lead_mask(input logic [2:0] t);
    unique case (t)
      3'd0:    lead_mask = 8'h7F;
      3'd1:    lead_mask = 8'h1F;
      3'd2:    lead_mask = 8'h0F;
      3'd3:    lead_mask = 8'h07;
      3'd4:    lead_mask = 8'h03;
      default: lead_mask = 8'h01;
    endcase
  endfunction

  assign trail = trail_count(in_byte);

  // Fold the byte into the sequence: a new lead byte, or one more trailing byte.
  always_comb begin
    upd_lead    = lead_r;
    upd_total   = total_r;
    upd_pending = pending_r;
    upd_second  = second_r;
    upd_tail    = tail_r;
    upd_acc     = acc_r;
    if (pending_r == 3'd0) begin
      upd_lead    = in_byte;
      upd_total   = trail + 3'd1;
      upd_pending = trail;
      upd_second  = 8'h00;
      upd_tail    = 1'b0;
      upd_acc     = {13'd0, in_byte & lead_mask(trail)};
    end else begin
      if (total_r - pending_r == 3'd1) begin
        upd_second = in_byte;
      end else if (in_byte < CONT_MIN || in_byte > CONT_MAX) begin
        upd_tail = 1'b1;
      end
      upd_acc     = {acc_r[14:0], in_byte[5:0]};
      upd_pending = pending_r - 3'd1;
    end
  end

  assign len_bad  = (upd_total == 3'd0) || (upd_total > 3'd4);
  assign lead_bad = (upd_lead >= CONT_MIN && upd_lead < LEAD_MIN_OK) ||
                    (upd_lead > LEAD_MAX_OK);

  always_comb begin
    second_bad = 1'b0;
    if (upd_total >= 3'd2) begin
      priority if (upd_second > CONT_MAX) second_bad = 1'b1;
      else if (upd_lead == LEAD_E0)       second_bad = upd_second < E0_SEC_MIN;
      else if (upd_lead == LEAD_F0)       second_bad = upd_second < F0_SEC_MIN;
      else if (upd_lead == LEAD_F4)       second_bad = (upd_second < CONT_MIN) ||
                                                       (upd_second > F4_SEC_MAX);
      else                                second_bad = upd_second < CONT_MIN;
    end
  end

  assign is_bmp  = upd_acc <= CP_BMP_MAX;
  assign is_surr = (upd_acc >= CP_SURR_LO) && (upd_acc <= CP_SURR_HI);
  assign is_over = upd_acc > CP_MAX;
  assign ch_off  = upd_acc - CP_PLANE1;
  assign illegal = len_bad || lead_bad || second_bad || upd_tail ||
                   (strict_r && is_bmp && is_surr) || (strict_r && is_over);

  // Results and next state; finished or truncated sequences clear to idle, but an illegal one before in_eos discards.
  always_comb begin
    lead_nxt    = upd_lead;
    total_nxt   = upd_total;
    pending_nxt = upd_pending;
    second_nxt  = upd_second;
    tail_nxt    = upd_tail;
    acc_nxt     = upd_acc;
    disc_nxt    = disc_r;
    res         = '0;
    if (!in_fire || disc_r) begin
      lead_nxt    = lead_r;
      total_nxt   = total_r;
      pending_nxt = pending_r;
      second_nxt  = second_r;
      tail_nxt    = tail_r;
      acc_nxt     = acc_r;
    end
    if (in_fire && (disc_r ? in_eos : (upd_pending == 3'd0 || in_eos))) begin
      lead_nxt    = '0;
      total_nxt   = '0;
      pending_nxt = '0;
      second_nxt  = '0;
      tail_nxt    = 1'b0;
      acc_nxt     = '0;
    end
    if (in_fire) begin
      if (disc_r) begin
        if (in_eos) disc_nxt = 1'b0;
      end else if (upd_pending != 3'd0) begin
        if (in_eos) begin
          res.cnt       = 2'd1;
          res.r0.status = ST_TRUNC;
          res.r0.last   = 1'b1;
        end
      end else begin
        res.cnt = 2'd1;
        res.r0.last = 1'b1;
        priority if (illegal) begin
          res.r0.status = ST_ILLEGAL;
          disc_nxt      = !in_eos;
        end else if (is_bmp) begin
          res.r0.unit = upd_acc[15:0];
        end else if (is_over) begin
          res.r0.unit = REPL_CHAR;
        end else begin
          res.cnt       = 2'd2;
          res.r0.unit   = {HI_SURR_TAG, ch_off[19:10]};
          res.r0.last   = 1'b0;
          res.r1.unit   = {LO_SURR_TAG, ch_off[9:0]};
          res.r1.status = ST_OK;
          res.r1.last   = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strict_r  <= 1'b1;
      lead_r    <= '0;
      total_r   <= '0;
      pending_r <= '0;
      second_r  <= '0;
      tail_r    <= 1'b0;
      acc_r     <= '0;
      disc_r    <= 1'b0;
    end else begin
      if (cfg_we) strict_r <= cfg_strict;
      lead_r    <= lead_nxt;
      total_r   <= total_nxt;
      pending_r <= pending_nxt;
      second_r  <= second_nxt;
      tail_r    <= tail_nxt;
      acc_r     <= acc_nxt;
      disc_r    <= disc_nxt;
    end
  end

  `U8U16_ASSERT(a_disc_idle, disc_r |-> (pending_r == 3'd0 && total_r == 3'd0))
  `U8U16_ASSERT(a_pending_lt_total, (pending_r != 3'd0) |-> (pending_r < total_r))
  `U8U16_ASSERT(a_pair_shape, (res.cnt == 2'd2) |-> (!res.r0.last && res.r1.last))
  `U8U16_ASSERT_NEXT(a_eos_idle, in_fire && in_eos, pending_r == 3'd0 && !disc_r)

endmodule

`default_nettype wire

>>> hdl/u8u16_ofifo.sv
// Result buffer that takes up to two results a cycle and hands out one.
`default_nettype none
`include "utf8_to_utf16_decoder_defines.svh"

module u8u16_ofifo import u8u16_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire dec_out_t push,
  input  wire logic     pop_ready,
  output logic          head_valid,
  output result_t       head,
  output logic          room_ok
);

  result_t              mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_AW-1:0]   wr_inc;
  logic [FIFO_CW-1:0]   count_r, count_nxt;
  logic                 pop;

  assign head_valid = count_r != '0;
  assign head       = mem_r[rd_ptr_r];
  assign pop        = head_valid && pop_ready;
  // Leave room for a surrogate pair.
  assign room_ok    = count_r <= FIFO_CW'(FIFO_DEPTH - 2);

  assign wr_inc     = wr_ptr_r + FIFO_AW'(1);
  assign wr_ptr_nxt = wr_ptr_r + FIFO_AW'(push.cnt);
  assign rd_ptr_nxt = rd_ptr_r + FIFO_AW'(pop);
  assign count_nxt  = count_r + FIFO_CW'(push.cnt) - FIFO_CW'(pop);

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) mem_r[wr_ptr_r] <= push.r0;
    if (push.cnt == 2'd2) mem_r[wr_inc]   <= push.r1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `U8U16_ASSERT(a_no_overflow, count_r <= FIFO_CW'(FIFO_DEPTH))
  `U8U16_ASSERT(a_push_has_room, (push.cnt != 2'd0) |-> room_ok)
  `U8U16_ASSERT(a_empty_ptrs, (count_r == '0) |-> (wr_ptr_r == rd_ptr_r))

endmodule

`default_nettype wire

>>> hdl/utf8_to_utf16_decoder.sv
// Top level of the UTF-8 to UTF-16 stream decoder.
//
//   channel | dir | handshake               | content
//   --------+-----+-------------------------+-----------------------------------
//   cfg     | in  | cfg_valid / cfg_ready   | cfg_data = strict_mode
//   in      | in  | in_tvalid / in_tready   | in_tdata = byte, in_tlast = end of stream
//   out     | out | out_tvalid / out_tready | out_tdata = unit, out_tuser = status,
//           |     |                         | out_tlast = last result of the byte
//
// One byte is taken per cycle while in_tready is high; its results are written into the result buffer at the beat.
// A surrogate pair gives two results; a four-entry result buffer absorbs it.
// in_tready falls while the buffer holds more than two results (out_tready low).
// Reset is synchronous; the block is ready in the first cycle after it.
`default_nettype none

module utf8_to_utf16_decoder import u8u16_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_data,    // [0] strict_mode
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,    // [7:0] in_byte
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,   // [15:0] code_unit
  output logic [1:0]       out_tuser,   // [1:0] status
  output logic             out_tlast
);

  dec_out_t dec;
  result_t  head;
  logic     room_ok;
  logic     in_fire;

  assign cfg_ready = 1'b1;
  assign in_tready = room_ok;
  assign in_fire   = in_tvalid && room_ok;

  u8u16_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_valid),
    .cfg_strict (cfg_data),
    .in_fire    (in_fire),
    .in_byte    (in_tdata),
    .in_eos     (in_tlast),
    .res        (dec)
  );

  u8u16_ofifo u_ofifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (dec),
    .pop_ready  (out_tready),
    .head_valid (out_tvalid),
    .head       (head),
    .room_ok    (room_ok)
  );

  assign out_tdata = head.unit;
  assign out_tuser = head.status;
  assign out_tlast = head.last;

endmodule

`default_nettype wire
